### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

### rtl/sqcq_pkg.sv
// Shared types, constants and helpers for the submission/completion queue pair.
// Depends on nothing; used by the top level, the ring memory user and the checker.
package sqcq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ADDR_W      = 48;
  localparam int FILL_W      = 8;
  localparam int CMD_W       = 16;

  localparam logic MODE_SUBMIT   = 1'b0;
  localparam logic MODE_DOORBELL = 1'b1;

  localparam logic KIND_ANSWER     = 1'b0;
  localparam logic KIND_COMPLETION = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] buffer;
    logic [FILL_W-1:0] fill;
    logic [CMD_W-1:0]  id;
  } sq_entry_t;

  localparam int ENTRY_W = $bits(sq_entry_t);

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == LAST_IDX) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

### rtl/sqcq_ram.sv
// Simple dual-port synchronous RAM, one write and one read port, registered read.
// Depends on nothing; holds the submission ring entries.
module sqcq_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/submission_completion_queue_pair_unit.sv
// Submission/completion queue pair: submission ring store, doorbell drain, result register.
// Depends on sqcq_pkg and sqcq_ram.
// A submit item yields one answer item (stored with its command id, or refused when the
// ring holds QUEUE_DEPTH-1 entries). A doorbell item with n pending entries yields n
// completion items: the first entry is read from the ring memory, then one completion item
// per cycle while the result register is free, paced by the single registered read port.
// A doorbell with nothing pending yields no item. Input is stalled while a drain runs or
// while the result register holds an item that is not being taken.
module submission_completion_queue_pair_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           mode,
  input  logic [sqcq_pkg::ADDR_W-1:0]    lba,
  input  logic [sqcq_pkg::ADDR_W-1:0]    buffer_address,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic                           kind,
  output logic                           accepted,
  output logic [sqcq_pkg::CMD_W-1:0]     cmd_tag,
  output logic [sqcq_pkg::IDX_W-1:0]     sq_head_now,
  output logic                           phase,
  output logic [sqcq_pkg::IDX_W-1:0]     cq_slot,
  output logic [sqcq_pkg::ADDR_W-1:0]    dma_address,
  output logic [sqcq_pkg::FILL_W-1:0]    fill_byte,
  output logic                           last
);

  sqcq_pkg::state_t state, state_next;

  logic [sqcq_pkg::IDX_W-1:0] sq_tail, sq_tail_next;
  logic [sqcq_pkg::IDX_W-1:0] sq_head, sq_head_next;
  logic [sqcq_pkg::IDX_W-1:0] pub_tail, pub_tail_next;
  logic [sqcq_pkg::IDX_W-1:0] cq_tail, cq_tail_next;
  logic [sqcq_pkg::CMD_W-1:0] next_cmd, next_cmd_next;
  logic                       phase_bit, phase_bit_next;

  logic                       slot_free;
  logic                       accept;
  logic                       load;
  logic                       ram_we;
  logic                       ram_re;
  logic [sqcq_pkg::IDX_W-1:0] ram_raddr;
  sqcq_pkg::sq_entry_t        wr_entry;
  sqcq_pkg::sq_entry_t        rd_entry;

  logic                        kind_next;
  logic                        accepted_next;
  logic [sqcq_pkg::CMD_W-1:0]  cmd_tag_next;
  logic [sqcq_pkg::IDX_W-1:0]  sq_head_now_next;
  logic                        phase_next;
  logic [sqcq_pkg::IDX_W-1:0]  cq_slot_next;
  logic [sqcq_pkg::ADDR_W-1:0] dma_address_next;
  logic [sqcq_pkg::FILL_W-1:0] fill_byte_next;
  logic                        last_next;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == sqcq_pkg::S_IDLE) && slot_free);
  assign accept    = req_valid && !req_stall;

  assign wr_entry.buffer = buffer_address;
  assign wr_entry.fill   = lba[sqcq_pkg::FILL_W-1:0];
  assign wr_entry.id     = next_cmd;

  sqcq_ram #(
    .WIDTH (sqcq_pkg::ENTRY_W),
    .DEPTH (sqcq_pkg::QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sq_tail),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  always_comb begin
    state_next       = state;
    sq_tail_next     = sq_tail;
    sq_head_next     = sq_head;
    pub_tail_next    = pub_tail;
    cq_tail_next     = cq_tail;
    next_cmd_next    = next_cmd;
    phase_bit_next   = phase_bit;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_raddr        = sq_head;
    load             = 1'b0;
    kind_next        = sqcq_pkg::KIND_ANSWER;
    accepted_next    = 1'b0;
    cmd_tag_next     = '0;
    sq_head_now_next = '0;
    phase_next       = 1'b0;
    cq_slot_next     = '0;
    dma_address_next = '0;
    fill_byte_next   = '0;
    last_next        = 1'b1;

    unique case (state)
      sqcq_pkg::S_IDLE: begin
        if (accept) begin
          if (mode == sqcq_pkg::MODE_SUBMIT) begin
            load = 1'b1;
            if (sqcq_pkg::advance(sq_tail) != sq_head) begin
              ram_we          = 1'b1;
              accepted_next   = 1'b1;
              cmd_tag_next    = next_cmd;
              next_cmd_next   = next_cmd + sqcq_pkg::CMD_W'(1);
              sq_tail_next    = sqcq_pkg::advance(sq_tail);
            end
          end else begin
            pub_tail_next = sq_tail;
            if (sq_head != sq_tail) begin
              ram_re     = 1'b1;
              state_next = sqcq_pkg::S_FETCH;
            end
          end
        end
      end
      sqcq_pkg::S_FETCH: begin
        if (slot_free) begin
          load             = 1'b1;
          sq_head_next     = sqcq_pkg::advance(sq_head);
          cq_tail_next     = sqcq_pkg::advance(cq_tail);
          if (cq_tail == sqcq_pkg::LAST_IDX) begin
            phase_bit_next = !phase_bit;
          end
          kind_next        = sqcq_pkg::KIND_COMPLETION;
          accepted_next    = 1'b1;
          cmd_tag_next     = rd_entry.id;
          sq_head_now_next = sq_head_next;
          phase_next       = phase_bit;
          cq_slot_next     = cq_tail;
          dma_address_next = rd_entry.buffer;
          fill_byte_next   = rd_entry.fill;
          last_next        = (sq_head_next == pub_tail);
          if (sq_head_next == pub_tail) begin
            state_next = sqcq_pkg::S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = sq_head_next;
          end
        end
      end
      default: begin
        state_next = sqcq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sqcq_pkg::S_IDLE;
      sq_tail   <= '0;
      sq_head   <= '0;
      pub_tail  <= '0;
      cq_tail   <= '0;
      next_cmd  <= '0;
      phase_bit <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sq_tail   <= sq_tail_next;
      sq_head   <= sq_head_next;
      pub_tail  <= pub_tail_next;
      cq_tail   <= cq_tail_next;
      next_cmd  <= next_cmd_next;
      phase_bit <= phase_bit_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind        <= kind_next;
      accepted    <= accepted_next;
      cmd_tag     <= cmd_tag_next;
      sq_head_now <= sq_head_now_next;
      phase       <= phase_next;
      cq_slot     <= cq_slot_next;
      dma_address <= dma_address_next;
      fill_byte   <= fill_byte_next;
      last        <= last_next;
    end
  end

endmodule

### rtl/sqcq_checker.sv
// Port-level checks for the submission/completion queue pair, bound to the top level.
// Depends on sqcq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sqcq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic                        kind,
  input logic                        accepted,
  input logic [sqcq_pkg::CMD_W-1:0]  cmd_tag,
  input logic                        last
);

  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(cmd_tag))
  `ASSERT_IMPLIES(a_answer_last, clk, rst, rsp_valid && (kind == sqcq_pkg::KIND_ANSWER), last)
  `ASSERT_IMPLIES(a_refused_zero_id, clk, rst, rsp_valid && !kind && !accepted, cmd_tag == '0)
  `ASSERT_IMPLIES(a_completion_acc, clk, rst, rsp_valid && kind, accepted)

endmodule

bind submission_completion_queue_pair_unit sqcq_checker u_sqcq_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp_valid),
  .rsp_stall  (rsp_stall),
  .kind       (kind),
  .accepted   (accepted),
  .cmd_tag    (cmd_tag),
  .last       (last)
);
